[hw/rtl/lrukv_pkg.sv]
`default_nettype none

package lrukv_pkg;

    localparam int ENTRIES  = 16;
    localparam int KEY_W    = 16;
    localparam int VALUE_W  = 32;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int RANK_W   = IDX_W;
    localparam int OCC_W    = $clog2(ENTRIES + 1);
    localparam int CAP_W    = 5;
    localparam int CMP_W    = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int REGSEL_W = PADDR_W - 2;

    localparam logic [CAP_W-1:0]    CAP_RESET    = CAP_W'(16);
    localparam logic [REGSEL_W-1:0] REG_CAPACITY = REGSEL_W'(0);

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    typedef struct packed {
        logic                      func;
        logic [KEY_W-1:0]          key;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                      hit;
        logic signed [VALUE_W-1:0] read_value;
    } rsp_t;

    // Search token, walks the cell chain one cell per cycle
    typedef struct packed {
        logic               hit;
        logic [IDX_W-1:0]   hit_idx;
        logic [RANK_W-1:0]  hit_rank;
        logic [VALUE_W-1:0] hit_data;
        logic               free_seen;
        logic [IDX_W-1:0]   free_idx;
        logic               evict_seen;
        logic [IDX_W-1:0]   evict_idx;
    } srch_t;

    // Update command, broadcast to every cell
    typedef struct packed {
        logic               en;
        logic               age_all;
        logic [RANK_W-1:0]  age_limit;
        logic [IDX_W-1:0]   slot;
        logic               wr_key;
        logic               wr_data;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] data;
    } upd_t;

endpackage

`default_nettype wire

[hw/rtl/lrukv_cell.sv]
`default_nettype none

module lrukv_cell (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [lrukv_pkg::IDX_W-1:0]  idx,
    input  wire logic [lrukv_pkg::KEY_W-1:0]  key,
    input  wire logic [lrukv_pkg::RANK_W-1:0] evict_rank,
    input  wire lrukv_pkg::srch_t             tok_in,
    output lrukv_pkg::srch_t                  tok_out,
    input  wire lrukv_pkg::upd_t              cmd
);
    import lrukv_pkg::*;

    logic [KEY_W-1:0]   key_reg,   key_next;
    logic [VALUE_W-1:0] data_reg,  data_next;
    logic               valid_reg, valid_next;
    logic [RANK_W-1:0]  rank_reg,  rank_next;
    srch_t              tok_reg,   tok_next;
    logic               mine;
    logic               match;

    assign mine  = cmd.en && (cmd.slot == idx);
    assign match = valid_reg && (key_reg == key);

    // entry update
    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        key_next   = key_reg;
        data_next  = data_reg;
        if (mine)
        begin
            rank_next = '0;
            if (cmd.wr_key)
            begin
                key_next   = cmd.key;
                valid_next = 1'b1;
            end
            if (cmd.wr_data)
            begin
                data_next = cmd.data;
            end
        end
        else if (cmd.en && valid_reg && (cmd.age_all || rank_reg < cmd.age_limit))
        begin
            rank_next = rank_reg + RANK_W'(1);
        end
    end

    // search token, first match / first free / oldest entry
    always_comb
    begin
        tok_next = tok_in;
        if (match && !tok_in.hit)
        begin
            tok_next.hit      = 1'b1;
            tok_next.hit_idx  = idx;
            tok_next.hit_rank = rank_reg;
            tok_next.hit_data = data_reg;
        end
        if (!valid_reg && !tok_in.free_seen)
        begin
            tok_next.free_seen = 1'b1;
            tok_next.free_idx  = idx;
        end
        if (valid_reg && (rank_reg == evict_rank) && !tok_in.evict_seen)
        begin
            tok_next.evict_seen = 1'b1;
            tok_next.evict_idx  = idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        data_reg <= data_next;
        tok_reg  <= tok_next;
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

[hw/rtl/lru_key_value_cache_top.sv]
`default_nettype none
// A request's response is registered once the search token has walked the chain, one cell
//   per cycle, and the response register is free.
// Requests are searched one at a time; the next request is taken
//   the cycle after the update, even while the previous response still waits.
// Reset: async active low; clears valid marks, ranks, occupancy; capacity = 16.

module lru_key_value_cache_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // request channel
    input  wire logic                           req_valid,
    output logic                                req_ready,
    input  wire lrukv_pkg::req_t                req,
    // response channel
    output logic                                rsp_valid,
    input  wire logic                           rsp_ready,
    output lrukv_pkg::rsp_t                     rsp,
    // configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lrukv_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [lrukv_pkg::PDATA_W-1:0]  pwdata,
    output logic [lrukv_pkg::PDATA_W-1:0]       prdata,
    output logic                                pready
);
    import lrukv_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } state_t;

    state_t             state_reg,     state_next;
    logic [OCC_W-1:0]   cnt_reg,       cnt_next;
    logic [OCC_W-1:0]   occ_reg,       occ_next;
    req_t               req_reg,       req_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg,       rsp_next;
    logic [CAP_W-1:0]   cap_reg;

    srch_t              chain [ENTRIES+1];
    srch_t              tail;
    upd_t               cmd;
    logic [RANK_W-1:0]  evict_rank;
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   cap_eff;
    logic               evict;
    logic               is_put;
    logic               slot_ok;
    logic               done;
    logic               fire;
    logic               cfg_wr;

    // ------------------------------------------------------------------
    // Configuration: one register, capacity, at byte address 0.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_CAPACITY);
    assign prdata = (paddr[PADDR_W-1:2] == REG_CAPACITY) ? PDATA_W'(cap_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr)
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    // Capacity of zero acts as one; above the entry count it saturates.
    assign cap_ext = CMP_W'(cap_reg);
    always_comb
    begin
        if (cap_ext == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            cap_eff = CMP_W'(ENTRIES);
        end
        else
        begin
            cap_eff = cap_ext;
        end
    end

    // ------------------------------------------------------------------
    // Cell chain. The search token enters cell 0 empty; each cell adds its
    // own findings and hands it on, so once it has passed every cell the
    // tail holds the hit entry, the lowest free slot and the least recent entry.
    // Valid ranks always form 0..occupancy-1, so the least recent entry is
    // the one whose rank equals occupancy-1.
    // ------------------------------------------------------------------
    assign chain[0]   = '0;
    assign evict_rank = RANK_W'(occ_reg - OCC_W'(1));

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lrukv_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .idx        (IDX_W'(i)),
            .key        (req_reg.key),
            .evict_rank (evict_rank),
            .tok_in     (chain[i]),
            .tok_out    (chain[i+1]),
            .cmd        (cmd)
        );
    end

    assign tail = chain[ENTRIES];

    // ------------------------------------------------------------------
    // Decision: once the token has reached the tail and the response
    // register is free, broadcast one update to the cells on a hit or a put.
    // ------------------------------------------------------------------
    assign is_put  = (req_reg.func == FUNC_PUT);
    assign evict   = (CMP_W'(occ_reg) >= cap_eff);
    assign slot_ok = evict ? tail.evict_seen : tail.free_seen;
    assign done    = (state_reg == S_SEARCH) && (cnt_reg == OCC_W'(ENTRIES));
    assign fire    = done && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        cmd.en        = fire && (tail.hit || (is_put && slot_ok));
        cmd.age_all   = !tail.hit;
        cmd.age_limit = tail.hit_rank;
        cmd.slot      = tail.hit ? tail.hit_idx : (evict ? tail.evict_idx : tail.free_idx);
        cmd.wr_key    = !tail.hit;
        cmd.wr_data   = is_put;
        cmd.key       = req_reg.key;
        cmd.data      = req_reg.value;
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        occ_next       = occ_reg;
        req_next       = req_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    cnt_next   = '0;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (!done)
                begin
                    cnt_next = cnt_reg + OCC_W'(1);
                end
                else if (fire)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.hit        = tail.hit;
                    rsp_next.read_value = (tail.hit && !is_put) ? tail.hit_data : '0;
                    // an eviction keeps occupancy; a fill grows it
                    if (is_put && !tail.hit && !evict && tail.free_seen)
                    begin
                        occ_next = occ_reg + OCC_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            req_reg       <= '0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            occ_reg       <= occ_next;
            rsp_valid_reg <= rsp_valid_next;
            req_reg       <= req_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(ENTRIES))
        else $error("occupancy above entry count");

    a_hit_keeps_occ: assert property (@(posedge clk) disable iff (!rst_n)
        fire && tail.hit |=> $stable(occ_reg))
        else $error("occupancy changed on a hit");

    a_put_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_put && !tail.hit |-> slot_ok)
        else $error("put miss found no slot");

    a_zero_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !tail.hit |=> rsp_valid_reg && (rsp_reg.read_value == '0))
        else $error("miss returned data");

endmodule

`default_nettype wire

[bench/lrukv_checker.sv]
`timescale 1ns / 1ps

module lrukv_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    input  wire logic                           req_ready,
    input  wire lrukv_pkg::req_t                req,
    input  wire logic                           rsp_valid,
    input  wire logic                           rsp_ready,
    input  wire lrukv_pkg::rsp_t                rsp,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lrukv_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [lrukv_pkg::PDATA_W-1:0]  pwdata,
    input  wire logic                           pready,
    output int                                  errors,
    output int                                  pending
);

    // shadow copy of the cache
    logic [lrukv_pkg::KEY_W-1:0]   slot_key  [lrukv_pkg::ENTRIES];
    logic [lrukv_pkg::VALUE_W-1:0] slot_data [lrukv_pkg::ENTRIES];
    logic                          slot_used [lrukv_pkg::ENTRIES];
    logic [lrukv_pkg::RANK_W-1:0]  slot_age  [lrukv_pkg::ENTRIES];
    logic [lrukv_pkg::OCC_W-1:0]   fill;
    logic [lrukv_pkg::CAP_W-1:0]   cap_reg;

    lrukv_pkg::rsp_t due_rsps [$];
    lrukv_pkg::rsp_t want_rsp;
    int              mismatches;

    // Applies one request to the shadow cache, returns the response it should give
    function automatic lrukv_pkg::rsp_t cache_access(input lrukv_pkg::req_t r);
        lrukv_pkg::rsp_t             res;
        int                          found;
        int                          slot;
        int                          eff;
        logic [lrukv_pkg::RANK_W-1:0] limit;
        logic [lrukv_pkg::RANK_W-1:0] worst;
        res   = '0;
        found = -1;
        slot  = -1;
        worst = '0;
        eff   = int'(cap_reg);
        if (eff == 0)
            eff = 1;
        if (eff > lrukv_pkg::ENTRIES)
            eff = lrukv_pkg::ENTRIES;

        for (int i = 0; i < lrukv_pkg::ENTRIES; i++)
            if (found < 0 && slot_used[i] && slot_key[i] == r.key)
                found = i;

        if (found >= 0)
        begin
            res.hit = 1'b1;
            if (r.func == lrukv_pkg::FUNC_PUT)
                slot_data[found] = r.value;
            else
                res.read_value = slot_data[found];
            limit = slot_age[found];
            for (int i = 0; i < lrukv_pkg::ENTRIES; i++)
                if (slot_used[i] && slot_age[i] < limit)
                    slot_age[i] = slot_age[i] + lrukv_pkg::RANK_W'(1);
            slot_age[found] = '0;
            return res;
        end

        if (r.func == lrukv_pkg::FUNC_GET)
            return res;

        // evict least recent; ties go to the highest slot
        if (int'(fill) >= eff)
        begin
            for (int i = 0; i < lrukv_pkg::ENTRIES; i++)
                if (slot_used[i] && (slot < 0 || slot_age[i] >= worst))
                begin
                    worst = slot_age[i];
                    slot  = i;
                end
            if (slot >= 0)
            begin
                slot_used[slot] = 1'b0;
                if (fill != '0)
                    fill = fill - lrukv_pkg::OCC_W'(1);
            end
        end
        if (slot < 0)
            for (int i = 0; i < lrukv_pkg::ENTRIES; i++)
                if (slot < 0 && !slot_used[i])
                    slot = i;
        if (slot < 0)
            return res;

        for (int i = 0; i < lrukv_pkg::ENTRIES; i++)
            if (slot_used[i])
                slot_age[i] = slot_age[i] + lrukv_pkg::RANK_W'(1);
        slot_key[slot]  = r.key;
        slot_data[slot] = r.value;
        slot_used[slot] = 1'b1;
        slot_age[slot]  = '0;
        fill            = fill + lrukv_pkg::OCC_W'(1);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lrukv_pkg::ENTRIES; i++)
            begin
                slot_used[i] = 1'b0;
                slot_age[i]  = '0;
            end
            fill       = '0;
            cap_reg    = lrukv_pkg::CAP_RESET;
            mismatches = 0;
            due_rsps.delete();
            pending <= 0;
            errors  <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready &&
                paddr[lrukv_pkg::PADDR_W-1:2] == lrukv_pkg::REG_CAPACITY)
                cap_reg = pwdata[lrukv_pkg::CAP_W-1:0];

            if (rsp_valid && rsp_ready)
            begin
                if (due_rsps.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, got hit=%0b value=%0d",
                             $time, rsp.hit, rsp.read_value);
                    mismatches++;
                end
                else
                begin
                    want_rsp = due_rsps.pop_front();
                    if (rsp.hit !== want_rsp.hit)
                    begin
                        $display("%0t: hit mismatch, expected %0b, got %0b",
                                 $time, want_rsp.hit, rsp.hit);
                        mismatches++;
                    end
                    if (rsp.read_value !== want_rsp.read_value)
                    begin
                        $display("%0t: read_value mismatch, expected %0d, got %0d",
                                 $time, want_rsp.read_value, rsp.read_value);
                        mismatches++;
                    end
                end
            end

            if (req_valid && req_ready)
                due_rsps.push_back(cache_access(req));

            pending <= due_rsps.size();
            errors  <= mismatches;
        end
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 160;

    // every block input has a known value from time zero
    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          req_valid = 1'b0;
    logic                          req_ready;
    lrukv_pkg::req_t               req       = '0;
    logic                          rsp_valid;
    logic                          rsp_ready = 1'b0;
    lrukv_pkg::rsp_t               rsp;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [lrukv_pkg::PADDR_W-1:0] paddr     = '0;
    logic [lrukv_pkg::PDATA_W-1:0] pwdata    = '0;
    logic [lrukv_pkg::PDATA_W-1:0] prdata;
    logic                          pready;

    int errors;
    int pending;

    // sender burst bookkeeping: requests left before the next gap
    int burst_left = 0;

    // receiver stall pattern: mode held for a random span of cycles
    int ready_span = 0;
    int ready_mode = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    lru_key_value_cache_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    lrukv_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .errors    (errors),
        .pending   (pending)
    );

    // Receiver: always ready, coin-toss ready, or mostly stalled, each for a while.
    // Stalls back up through the single response slot into the request side.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready  <= 1'b0;
            ready_span <= 0;
            ready_mode <= 0;
        end
        else
        begin
            if (ready_span == 0)
            begin
                ready_mode <= $urandom_range(0, 2);
                ready_span <= $urandom_range(8, 200);
            end
            else
                ready_span <= ready_span - 1;
            case (ready_mode)
                0:       rsp_ready <= 1'b1;
                1:       rsp_ready <= 1'($urandom_range(0, 1));
                default: rsp_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Presents one request and holds it until taken. Within a burst the next
    // request follows at the acceptance edge with valid left high; between
    // bursts valid drops for a random gap, so gaps land on every phase of
    // the search.
    task automatic send_req(input lrukv_pkg::req_t r);
        if (burst_left == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            burst_left = $urandom_range(1, 30);
        end
        req        <= r;
        req_valid  <= 1'b1;
        burst_left  = burst_left - 1;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic send_op(input logic func, input logic [15:0] key, input logic [31:0] value);
        lrukv_pkg::req_t r;
        r.func  = func;
        r.key   = key;
        r.value = value;
        send_req(r);
    endtask

    // Wait until every request has had its response, then let the block settle.
    // The first edge is needed because pending is registered and lags the acceptance.
    task automatic wait_idle();
        req_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (lrukv_pkg::ENTRIES + 4) @(posedge clk);
    endtask

    // Two-phase APB write; upper data bits are junk, only the low five count
    task automatic set_capacity(input logic [lrukv_pkg::CAP_W-1:0] cap);
        logic [lrukv_pkg::PDATA_W-1:0] data;
        data                      = $urandom;
        data[lrukv_pkg::CAP_W-1:0] = cap;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {lrukv_pkg::REG_CAPACITY, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        lrukv_pkg::req_t             r;
        logic [lrukv_pkg::KEY_W-1:0] key_pool [$];
        logic [lrukv_pkg::CAP_W-1:0] phase_caps [PHASES];
        logic [lrukv_pkg::CAP_W-1:0] cap;
        logic [lrukv_pkg::KEY_W-1:0] k;
        int                          eff;
        int                          pool_len;

        // 31 fills all sixteen slots, then 3 drops capacity under occupancy
        phase_caps = '{5'd31, 5'd3, 5'd16, 5'd1, 5'd0, 5'd2, 5'd17, 5'd0, 5'd8, 5'd16};
        phase_caps[7] = lrukv_pkg::CAP_W'($urandom_range(0, 31));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part, reset capacity of 16 ---
        send_op(lrukv_pkg::FUNC_GET, 16'h0000, 32'h0000_0000);   // miss on empty cache
        send_op(lrukv_pkg::FUNC_PUT, 16'h0000, 32'h8000_0000);
        send_op(lrukv_pkg::FUNC_PUT, 16'hFFFF, 32'h7FFF_FFFF);
        send_op(lrukv_pkg::FUNC_GET, 16'h0000, 32'hFFFF_FFFF);   // hit, most negative
        send_op(lrukv_pkg::FUNC_GET, 16'hFFFF, 32'h0000_0000);   // hit, most positive
        send_op(lrukv_pkg::FUNC_PUT, 16'h0000, 32'hFFFF_FFFF);   // overwrite present key
        send_op(lrukv_pkg::FUNC_GET, 16'h0000, 32'h0000_0000);
        send_op(lrukv_pkg::FUNC_GET, 16'h5A5A, 32'hFFFF_FFFF);   // miss, value ignored
        wait_idle();

        // capacity 2 with two entries present: a new key evicts the oldest
        set_capacity(5'd2);
        send_op(lrukv_pkg::FUNC_PUT, 16'h00A5, 32'h1234_5678);
        send_op(lrukv_pkg::FUNC_GET, 16'hFFFF, 32'h0000_0000);   // evicted
        send_op(lrukv_pkg::FUNC_GET, 16'h0000, 32'h0000_0000);
        send_op(lrukv_pkg::FUNC_PUT, 16'h5A5A, 32'h0000_0000);   // evicts 00A5, slot reused
        send_op(lrukv_pkg::FUNC_GET, 16'h00A5, 32'h0000_0000);
        wait_idle();

        // capacity 0 acts as 1, and sits below occupancy: puts keep occupancy flat
        set_capacity(5'd0);
        send_op(lrukv_pkg::FUNC_PUT, 16'h1111, 32'h0000_0001);
        send_op(lrukv_pkg::FUNC_PUT, 16'h2222, 32'h0000_0002);
        send_op(lrukv_pkg::FUNC_GET, 16'h1111, 32'h0000_0000);
        send_op(lrukv_pkg::FUNC_GET, 16'h2222, 32'h0000_0000);
        wait_idle();

        // --- random phases, one capacity each ---
        for (int p = 0; p < PHASES; p++)
        begin
            cap = phase_caps[p];
            set_capacity(cap);
            eff = int'(cap);
            if (eff == 0)
                eff = 1;
            if (eff > lrukv_pkg::ENTRIES)
                eff = lrukv_pkg::ENTRIES;

            // a key pool a little larger than capacity gives a mix of hits,
            // updates and evictions; the key extremes turn up now and then
            key_pool.delete();
            pool_len = eff + $urandom_range(0, 4);
            for (int i = 0; i < pool_len; i++)
            begin
                case ($urandom_range(0, 7))
                    0:       k = '0;
                    1:       k = '1;
                    default: k = lrukv_pkg::KEY_W'($urandom);
                endcase
                key_pool.push_back(k);
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                r.func = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 4) != 0)
                    r.key = key_pool[$urandom_range(0, pool_len - 1)];
                else
                    r.key = lrukv_pkg::KEY_W'($urandom);
                r.value = $urandom;
                send_req(r);
            end
            wait_idle();
        end

        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: worst case is well under half of this
    initial
    begin
        #15ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[lru_key_value_cache_top.f]
hw/rtl/lrukv_pkg.sv
hw/rtl/lrukv_cell.sv
hw/rtl/lru_key_value_cache_top.sv
bench/lrukv_checker.sv
bench/testbench.sv
